// File: hdl/acbc_pkg.sv
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types, constants and AES round functions for the CBC encryptor.
// ----------------------------------------------------------------------------
package acbc_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
	localparam int CNT_W       = $clog2(BLOCK_BYTES);
	localparam int ROUNDS      = 10;
	localparam int ROUND_W     = 4;

	// register indexes of the configuration port
	localparam logic [1:0] IDX_KEY_HIGH = 2'd0;
	localparam logic [1:0] IDX_KEY_LOW  = 2'd1;
	localparam logic [1:0] IDX_IV_HIGH  = 2'd2;
	localparam logic [1:0] IDX_IV_LOW   = 2'd3;

	localparam logic [63:0] IV_HIGH_RST = 64'h0001020304050607;
	localparam logic [63:0] IV_LOW_RST  = 64'h08090A0B0C0D0E0F;

	// one block handed from the collector to the cipher
	typedef struct packed {
		logic [BLOCK_BITS-1:0] plain;
		logic                  last;
	} blk_item_t;

	// chain reload requests from the configuration port
	typedef struct packed {
		logic        load_hi;
		logic        load_lo;
		logic [63:0] data;
	} iv_load_t;

	typedef enum logic {
		CORE_IDLE,
		CORE_BUSY
	} core_state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
		logic [7:0] v;
		case (r)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] get_byte(input logic [BLOCK_BITS-1:0] x, input int i);
		return x[8*(BLOCK_BYTES-1-i) +: 8];
	endfunction

	// next round key from the previous one
	function automatic logic [BLOCK_BITS-1:0] key_step(input logic [BLOCK_BITS-1:0] rk,
			input logic [ROUND_W-1:0] r);
		logic [7:0] k [16];
		logic [7:0] n [16];
		logic [7:0] t [4];
		logic [BLOCK_BITS-1:0] o;
		for (int i = 0; i < 16; i++) k[i] = get_byte(rk, i);
		t[0] = SBOX[k[13]] ^ rcon(r);
		t[1] = SBOX[k[14]];
		t[2] = SBOX[k[15]];
		t[3] = SBOX[k[12]];
		for (int i = 0; i < 4; i++) n[i] = k[i] ^ t[i];
		for (int i = 4; i < 16; i++) n[i] = k[i] ^ n[i-4];
		for (int i = 0; i < 16; i++) o[8*(BLOCK_BYTES-1-i) +: 8] = n[i];
		return o;
	endfunction

	// one cipher round; the last round skips column mixing
	function automatic logic [BLOCK_BITS-1:0] aes_round(input logic [BLOCK_BITS-1:0] s,
			input logic [BLOCK_BITS-1:0] rk, input logic last);
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [BLOCK_BITS-1:0] o;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[i+4*c] = SBOX[get_byte(s, i + 4*((c+i) & 3))];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			all = a0 ^ a1 ^ a2 ^ a3;
			m[4*c]   = last ? a0 : (a0 ^ all ^ xtime(a0 ^ a1));
			m[4*c+1] = last ? a1 : (a1 ^ all ^ xtime(a1 ^ a2));
			m[4*c+2] = last ? a2 : (a2 ^ all ^ xtime(a2 ^ a3));
			m[4*c+3] = last ? a3 : (a3 ^ all ^ xtime(a3 ^ a0));
		end
		for (int i = 0; i < 16; i++) o[8*(BLOCK_BYTES-1-i) +: 8] = m[i];
		return o ^ rk;
	endfunction

endpackage

// File: hdl/acbc_front.sv
// ----------------------------------------------------------------------------
// acbc_front
// Collects message bytes into the open block and pads it at end of message.
// ----------------------------------------------------------------------------
module acbc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_acc,
	input  logic [7:0]          in_byte,
	input  logic                in_end,
	output logic                push,
	output acbc_pkg::blk_item_t push_item,
	output logic                in_msg
);

	logic [acbc_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                 blk_q [acbc_pkg::BLOCK_BYTES];
	logic                       msg_q;
	logic [7:0]                 pad;

	assign in_msg = msg_q;
	assign push   = in_acc && (in_end || (&cnt_q));
	assign pad    = 8'(5'd16 - {1'b0, cnt_q});

	// fill counter and message flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			msg_q <= 1'b0;
		end else if (in_acc) begin
			if (in_end) begin
				cnt_q <= '0;
				msg_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				msg_q <= 1'b1;
			end
		end
	end

	// open block storage
	always_ff @(posedge clk) begin
		if (in_acc && !in_end) blk_q[cnt_q] <= in_byte;
	end

	// block going to the queue: full block or padded tail
	always_comb begin
		push_item.last = in_end;
		for (int i = 0; i < acbc_pkg::BLOCK_BYTES; i++) begin
			if (in_end)
				push_item.plain[8*(acbc_pkg::BLOCK_BYTES-1-i) +: 8] =
					(i < int'(cnt_q)) ? blk_q[i] : pad;
			else
				push_item.plain[8*(acbc_pkg::BLOCK_BYTES-1-i) +: 8] =
					(i == acbc_pkg::BLOCK_BYTES-1) ? in_byte : blk_q[i];
		end
	end

endmodule

// File: hdl/acbc_fifo.sv
// ----------------------------------------------------------------------------
// acbc_fifo
// Two-entry queue of blocks between the collector and the cipher.
// ----------------------------------------------------------------------------
module acbc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  acbc_pkg::blk_item_t wr_item,
	input  logic                rd,
	output logic                full,
	output logic                not_empty,
	output acbc_pkg::blk_item_t rd_item
);

	acbc_pkg::blk_item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rd_item   = mem_q[rp_q];

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

endmodule

// File: hdl/acbc_core.sv
// ----------------------------------------------------------------------------
// acbc_core
// Iterative AES-128 CBC with output reg; one round per cycle unless output held.
// ----------------------------------------------------------------------------
module acbc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  acbc_pkg::blk_item_t q_item,
	output logic                q_pop,
	input  logic [127:0]        key,
	input  logic [127:0]        iv,
	input  acbc_pkg::iv_load_t  iv_load,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [127:0]        out_data,
	output logic                out_last
);

	acbc_pkg::core_state_t       st_q, st_d;
	logic [acbc_pkg::ROUND_W-1:0] round_q;
	logic [127:0] state_q, rk_q, chain_q, rk_nx, round_out;
	logic         last_q, ovalid_q, done, hold, adv;

	assign rk_nx     = acbc_pkg::key_step(rk_q, round_q);
	assign round_out = acbc_pkg::aes_round(state_q, rk_nx, round_q == 4'(acbc_pkg::ROUNDS));
	assign hold      = (round_q == 4'(acbc_pkg::ROUNDS)) && ovalid_q && !out_ready;
	assign adv       = (st_q == acbc_pkg::CORE_BUSY) && !hold;
	assign done      = adv && (round_q == 4'(acbc_pkg::ROUNDS));
	assign out_valid = ovalid_q;

	// sequencer
	always_comb begin
		st_d  = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			acbc_pkg::CORE_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					st_d  = acbc_pkg::CORE_BUSY;
				end
			end
			acbc_pkg::CORE_BUSY: begin
				if (done) st_d = acbc_pkg::CORE_IDLE;
			end
			default: st_d = acbc_pkg::CORE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= acbc_pkg::CORE_IDLE;
		else         st_q <= st_d;
	end

	// round datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			state_q <= q_item.plain ^ chain_q ^ key;
			rk_q    <= key;
			round_q <= 4'd1;
			last_q  <= q_item.last;
		end else if (adv) begin
			state_q <= round_out;
			rk_q    <= rk_nx;
			if (!done) round_q <= round_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (done) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data <= round_out;
			out_last <= last_q;
		end
	end

	// chain value: ciphertext, IV after the last block, or a direct IV load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= {acbc_pkg::IV_HIGH_RST, acbc_pkg::IV_LOW_RST};
		end else begin
			if (done) chain_q <= last_q ? iv : round_out;
			if (iv_load.load_hi) chain_q[127:64] <= iv_load.data;
			if (iv_load.load_lo) chain_q[63:0]   <= iv_load.data;
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == acbc_pkg::CORE_BUSY) |-> (round_q >= 4'd1 && round_q <= 4'd10))
		else $error("round counter out of range");
	a_start_round: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (round_q == 4'd1))
		else $error("round counter not reset at block start");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(st_q == acbc_pkg::CORE_BUSY && round_q == 4'd10))
		else $error("result without finished rounds");

endmodule

// File: hdl/aes128_cbc_encrypt_padded.sv
// ----------------------------------------------------------------------------
// aes128_cbc_encrypt_padded
// AES-128 CBC encryptor with PKCS#7 padding, fed one byte per item.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the two-block queue has room. Each 16th
// byte, or an end-of-message item (tlast), sends a block to an iterative
// AES-128 unit that runs one round per cycle unless its output register is
// held; a steady byte stream runs at one byte per cycle while m_tready keeps
// up, and back-to-back end items are paced by that round loop. The end item
// pads the open block (a full block of 16s if it is empty), the result is
// flagged with tlast and the chain reloads the IV. Configuration writes are
// taken every cycle; IV writes between messages load the chain at once.
module aes128_cbc_encrypt_padded (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // msg_byte
	input  logic         s_tlast,   // end_marker
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // cipher_high [63:0], cipher_low [127:64]
	output logic         m_tlast,   // final_block
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic        in_acc, push, full, q_valid, q_pop, in_msg, cfg_acc;
	logic [127:0] res;
	acbc_pkg::blk_item_t push_item, q_item;
	acbc_pkg::iv_load_t  iv_load;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid;
	assign s_tready  = !full;
	assign in_acc    = s_tvalid && s_tready;
	assign m_tdata   = {res[63:0], res[127:64]};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			iv_hi_q  <= acbc_pkg::IV_HIGH_RST;
			iv_lo_q  <= acbc_pkg::IV_LOW_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				acbc_pkg::IDX_KEY_HIGH: key_hi_q <= cfg_data;
				acbc_pkg::IDX_KEY_LOW:  key_lo_q <= cfg_data;
				acbc_pkg::IDX_IV_HIGH:  iv_hi_q  <= cfg_data;
				acbc_pkg::IDX_IV_LOW:   iv_lo_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign iv_load.load_hi = cfg_acc && (cfg_index == acbc_pkg::IDX_IV_HIGH) && !in_msg;
	assign iv_load.load_lo = cfg_acc && (cfg_index == acbc_pkg::IDX_IV_LOW) && !in_msg;
	assign iv_load.data    = cfg_data;

	acbc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_acc(in_acc), .in_byte(s_tdata),
		.in_end(s_tlast), .push(push), .push_item(push_item), .in_msg(in_msg)
	);

	acbc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(push), .wr_item(push_item), .rd(q_pop),
		.full(full), .not_empty(q_valid), .rd_item(q_item)
	);

	acbc_core u_core (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.key({key_hi_q, key_lo_q}), .iv({iv_hi_q, iv_lo_q}), .iv_load(iv_load),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(res), .out_last(m_tlast)
	);

endmodule
